// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the top-level RTL file of the inverse kinematics block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define TLIK_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define TLIK_ASSERT_NEVER(label, clk, rst_n, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("forbidden condition seen");
`else
`define TLIK_ASSERT(label, clk, rst_n, prop)
`define TLIK_ASSERT_NEVER(label, clk, rst_n, expr)
`endif
`endif

// ===== hw/rtl/tlik_pkg.sv =====
// Package with the shared constants, types and tables of the inverse kinematics block.
package tlik_pkg;

  localparam int CORDIC_STAGES_DEF = 16;
  localparam int POS_BITS_DEF      = 18;

  localparam int LINK_W     = 16;
  localparam logic [LINK_W-1:0] LINK_RESET = 16'd65024;

  localparam int ANG_W      = 19;
  localparam int SUM_W      = 21;
  localparam int POS_KEEP   = 18;
  localparam int POS_SCALE  = 8;
  localparam int VEC_W      = 28;
  localparam int LIM_W      = 34;
  localparam int SQ_SHIFT   = 16;
  localparam int RAD_W      = LIM_W + SQ_SHIFT;
  localparam int ROOT_W     = RAD_W / 2;
  localparam int LEN_W      = LINK_W + POS_SCALE;
  localparam int KINV_W     = 30;
  localparam logic [KINV_W-1:0] KINV_Q30 = 30'd652032874;

  localparam logic signed [ANG_W-1:0] HALF_PI_Q = 19'sd102944;
  localparam logic signed [SUM_W-1:0] PI_Q      = 21'sd205887;
  localparam logic signed [SUM_W-1:0] TWO_PI_Q  = 21'sd411775;
  localparam logic signed [SUM_W-1:0] ANG_LIMIT = 21'sd205888;

  // Side data that rides along with each item through the pipeline units.
  typedef struct packed {
    logic signed [POS_KEEP-1:0] x;
    logic signed [POS_KEEP-1:0] y;
    logic                       left;
    logic                       unreach;
    logic                       origin;
    logic [RAD_W-1:0]           rad_r;
    logic [RAD_W-1:0]           rad_h;
  } alpha_side_t;

  typedef struct packed {
    logic signed [POS_KEEP-1:0] x;
    logic signed [POS_KEEP-1:0] y;
    logic                       left;
    logic                       unreach;
    logic                       origin;
    logic signed [ANG_W-1:0]    alpha;
  } root_side_t;

  typedef struct packed {
    logic signed [POS_KEEP-1:0] x;
    logic signed [POS_KEEP-1:0] y;
    logic                       unreach;
    logic signed [ANG_W-1:0]    t1;
  } rot_side_t;

  typedef struct packed {
    logic                    unreach;
    logic signed [ANG_W-1:0] t1;
  } fin_side_t;

  // Arctangent of 2^-idx in 2^-16 rad, rounded to nearest.
  function automatic logic signed [ANG_W-1:0] arc_at(input int unsigned idx);
    logic signed [ANG_W-1:0] a;
    case (idx)
      0:       a = 19'sd51472;
      1:       a = 19'sd30385;
      2:       a = 19'sd16055;
      3:       a = 19'sd8150;
      4:       a = 19'sd4091;
      5:       a = 19'sd2047;
      6:       a = 19'sd1024;
      7:       a = 19'sd512;
      8:       a = 19'sd256;
      9:       a = 19'sd128;
      10:      a = 19'sd64;
      11:      a = 19'sd32;
      12:      a = 19'sd16;
      13:      a = 19'sd8;
      14:      a = 19'sd4;
      15:      a = 19'sd2;
      16:      a = 19'sd1;
      default: a = '0;
    endcase
    return a;
  endfunction

  function automatic logic signed [ANG_W-1:0] clamp_ang(input logic signed [SUM_W-1:0] a);
    logic signed [ANG_W-1:0] r;
    if (a > ANG_LIMIT) begin
      r = ANG_W'(ANG_LIMIT);
    end else if (a < -ANG_LIMIT) begin
      r = ANG_W'(-ANG_LIMIT);
    end else begin
      r = ANG_W'(a);
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/tlik_if.sv =====
// Valid/ready channel interfaces for targets and joint angles.
interface tlik_in_if #(
  parameter int POS_BITS = tlik_pkg::POS_BITS_DEF
);
  logic                       valid;
  logic                       ready;
  logic signed [POS_BITS-1:0] x_pos;
  logic signed [POS_BITS-1:0] y_pos;
  logic                       arm_left;

  modport source (output valid, x_pos, y_pos, arm_left, input ready);
  modport sink   (input valid, x_pos, y_pos, arm_left, output ready);
endinterface

interface tlik_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [tlik_pkg::ANG_W-1:0] shoulder_angle;
  logic signed [tlik_pkg::ANG_W-1:0] link2_angle;
  logic                              unreachable;

  modport source (output valid, shoulder_angle, link2_angle, unreachable, input ready);
  modport sink   (input valid, shoulder_angle, link2_angle, unreachable, output ready);
endinterface

// ===== hw/rtl/tlik_vec.sv =====
// Pipelined vectoring CORDIC that returns atan2(y, x) with side data carried along.
module tlik_vec #(
  parameter int STAGES = tlik_pkg::CORDIC_STAGES_DEF,
  parameter int SIDE_W = 1
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  logic                              valid_i,
  input  logic signed [tlik_pkg::VEC_W-1:0] x_i,
  input  logic signed [tlik_pkg::VEC_W-1:0] y_i,
  input  logic [SIDE_W-1:0]                 side_i,
  output logic                              valid_o,
  output logic signed [tlik_pkg::ANG_W-1:0] ang_o,
  output logic [SIDE_W-1:0]                 side_o
);
  import tlik_pkg::*;

  localparam int IW = VEC_W + 2;

  logic signed [IW-1:0]    x_q [0:STAGES];
  logic signed [IW-1:0]    y_q [0:STAGES];
  logic signed [ANG_W-1:0] z_q [0:STAGES];
  logic                    zero_q [0:STAGES];
  logic [SIDE_W-1:0]       side_q [0:STAGES];
  logic                    v_q [0:STAGES];

  logic signed [IW-1:0]    xe, ye, x0, y0;
  logic signed [ANG_W-1:0] z0;

  // Vectors in the left half plane are turned by a quarter turn first.
  always_comb begin
    xe = IW'(x_i);
    ye = IW'(y_i);
    x0 = xe;
    y0 = ye;
    z0 = '0;
    if (xe[IW-1]) begin
      if (!ye[IW-1]) begin
        x0 = ye;
        y0 = -xe;
        z0 = HALF_PI_Q;
      end else begin
        x0 = -ye;
        y0 = xe;
        z0 = -HALF_PI_Q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else if (en_i) begin
      v_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0]    <= x0;
      y_q[0]    <= y0;
      z_q[0]    <= z0;
      zero_q[0] <= (x_i == '0) && (y_i == '0);
      side_q[0] <= side_i;
    end
  end

  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    logic signed [IW-1:0]    dx, dy;
    logic signed [ANG_W-1:0] arc;
    logic                    pos;

    assign dx  = x_q[i] >>> i;
    assign dy  = y_q[i] >>> i;
    assign arc = arc_at(i);
    assign pos = !y_q[i][IW-1] && (y_q[i] != '0);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[i+1] <= 1'b0;
      end else if (en_i) begin
        v_q[i+1] <= v_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (pos) begin
          x_q[i+1] <= x_q[i] + dy;
          y_q[i+1] <= y_q[i] - dx;
          z_q[i+1] <= z_q[i] + arc;
        end else begin
          x_q[i+1] <= x_q[i] - dy;
          y_q[i+1] <= y_q[i] + dx;
          z_q[i+1] <= z_q[i] - arc;
        end
        zero_q[i+1] <= zero_q[i];
        side_q[i+1] <= side_q[i];
      end
    end
  end

  assign valid_o = v_q[STAGES];
  assign ang_o   = zero_q[STAGES] ? '0 : z_q[STAGES];
  assign side_o  = side_q[STAGES];

endmodule

// ===== hw/rtl/tlik_isqrt.sv =====
// Pipelined dual integer square root, one result bit per stage.
module tlik_isqrt #(
  parameter int SIDE_W = 1
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic                         valid_i,
  input  logic [tlik_pkg::RAD_W-1:0]   rad_a_i,
  input  logic [tlik_pkg::RAD_W-1:0]   rad_b_i,
  input  logic [SIDE_W-1:0]            side_i,
  output logic                         valid_o,
  output logic [tlik_pkg::ROOT_W-1:0]  root_a_o,
  output logic [tlik_pkg::ROOT_W-1:0]  root_b_o,
  output logic [SIDE_W-1:0]            side_o
);
  import tlik_pkg::*;

  localparam int EW = RAD_W + 2;

  logic [RAD_W-1:0]  ra_q [0:ROOT_W];
  logic [RAD_W-1:0]  rb_q [0:ROOT_W];
  logic [ROOT_W-1:0] qa_q [0:ROOT_W];
  logic [ROOT_W-1:0] qb_q [0:ROOT_W];
  logic [SIDE_W-1:0] side_q [0:ROOT_W];
  logic              v_q [0:ROOT_W];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else if (en_i) begin
      v_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ra_q[0]   <= rad_a_i;
      rb_q[0]   <= rad_b_i;
      qa_q[0]   <= '0;
      qb_q[0]   <= '0;
      side_q[0] <= side_i;
    end
  end

  // Each stage tries the next lower root bit: (q + 2^k)^2 - q^2 = 2^(k+1) q + 2^(2k).
  for (genvar j = 0; j < ROOT_W; j++) begin : g_bit
    localparam int K = ROOT_W - 1 - j;
    logic [EW-1:0] ta, tb;
    logic          ge_a, ge_b;

    assign ta   = (EW'(qa_q[j]) << (K + 1)) + (EW'(1) << (2 * K));
    assign tb   = (EW'(qb_q[j]) << (K + 1)) + (EW'(1) << (2 * K));
    assign ge_a = EW'(ra_q[j]) >= ta;
    assign ge_b = EW'(rb_q[j]) >= tb;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[j+1] <= 1'b0;
      end else if (en_i) begin
        v_q[j+1] <= v_q[j];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        ra_q[j+1]   <= ge_a ? RAD_W'(EW'(ra_q[j]) - ta) : ra_q[j];
        rb_q[j+1]   <= ge_b ? RAD_W'(EW'(rb_q[j]) - tb) : rb_q[j];
        qa_q[j+1]   <= ge_a ? (qa_q[j] | (ROOT_W'(1) << K)) : qa_q[j];
        qb_q[j+1]   <= ge_b ? (qb_q[j] | (ROOT_W'(1) << K)) : qb_q[j];
        side_q[j+1] <= side_q[j];
      end
    end
  end

  assign valid_o  = v_q[ROOT_W];
  assign root_a_o = qa_q[ROOT_W];
  assign root_b_o = qb_q[ROOT_W];
  assign side_o   = side_q[ROOT_W];

endmodule

// ===== hw/rtl/tlik_rot.sv =====
// Pipelined rotation CORDIC that returns len*cos(ang) and len*sin(ang).
module tlik_rot #(
  parameter int STAGES = tlik_pkg::CORDIC_STAGES_DEF,
  parameter int SIDE_W = 1
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  logic                              valid_i,
  input  logic [tlik_pkg::LEN_W-1:0]        len_i,
  input  logic signed [tlik_pkg::ANG_W-1:0] ang_i,
  input  logic [SIDE_W-1:0]                 side_i,
  output logic                              valid_o,
  output logic signed [tlik_pkg::VEC_W-1:0] cos_o,
  output logic signed [tlik_pkg::VEC_W-1:0] sin_o,
  output logic [SIDE_W-1:0]                 side_o
);
  import tlik_pkg::*;

  localparam int PW = LEN_W + KINV_W;

  logic [PW-1:0]           prod;
  logic                    p_v_q;
  logic signed [VEC_W-1:0] p_x_q;
  logic signed [ANG_W-1:0] p_ang_q;
  logic [SIDE_W-1:0]       p_side_q;

  logic signed [VEC_W-1:0] x_q [0:STAGES];
  logic signed [VEC_W-1:0] y_q [0:STAGES];
  logic signed [ANG_W-1:0] z_q [0:STAGES];
  logic [SIDE_W-1:0]       side_q [0:STAGES];
  logic                    v_q [0:STAGES];

  logic signed [VEC_W-1:0] x0, y0;
  logic signed [ANG_W-1:0] z0;

  // Start vector is the length scaled by the inverse CORDIC gain.
  assign prod = PW'(len_i) * PW'(KINV_Q30);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_v_q  <= 1'b0;
      v_q[0] <= 1'b0;
    end else if (en_i) begin
      p_v_q  <= valid_i;
      v_q[0] <= p_v_q;
    end
  end

  always_comb begin
    x0 = p_x_q;
    y0 = '0;
    z0 = p_ang_q;
    if (p_ang_q > HALF_PI_Q) begin
      x0 = '0;
      y0 = p_x_q;
      z0 = p_ang_q - HALF_PI_Q;
    end else if (p_ang_q < -HALF_PI_Q) begin
      x0 = '0;
      y0 = -p_x_q;
      z0 = p_ang_q + HALF_PI_Q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_x_q     <= VEC_W'(prod[PW-1:KINV_W]);
      p_ang_q   <= ang_i;
      p_side_q  <= side_i;
      x_q[0]    <= x0;
      y_q[0]    <= y0;
      z_q[0]    <= z0;
      side_q[0] <= p_side_q;
    end
  end

  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    logic signed [VEC_W-1:0] dx, dy;
    logic signed [ANG_W-1:0] arc;

    assign dx  = x_q[i] >>> i;
    assign dy  = y_q[i] >>> i;
    assign arc = arc_at(i);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[i+1] <= 1'b0;
      end else if (en_i) begin
        v_q[i+1] <= v_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (!z_q[i][ANG_W-1]) begin
          x_q[i+1] <= x_q[i] - dy;
          y_q[i+1] <= y_q[i] + dx;
          z_q[i+1] <= z_q[i] - arc;
        end else begin
          x_q[i+1] <= x_q[i] + dy;
          y_q[i+1] <= y_q[i] - dx;
          z_q[i+1] <= z_q[i] + arc;
        end
        side_q[i+1] <= side_q[i];
      end
    end
  end

  assign valid_o = v_q[STAGES];
  assign cos_o   = x_q[STAGES];
  assign sin_o   = y_q[STAGES];
  assign side_o  = side_q[STAGES];

endmodule

// ===== hw/rtl/two_link_inverse_kinematics.sv =====
// Top level of the two-link planar arm inverse kinematics pipeline.
//
// Usage: targets (x_pos, y_pos in 1/256 mm, arm_left picks the elbow side)
// enter on the in_ch valid/ready channel; one transfer on out_ch follows for
// each target with shoulder_angle and link2_angle in 2^-16 rad and the
// unreachable flag (angles then zero). The link length is written through
// cfg_we_i/cfg_wdata_i while no target is in flight.
// The pipeline holds the stage A and B registers for squaring and the reach
// test inputs, four CORDIC units of CORDIC_STAGES+1 or +2 stages, a 26-stage
// dual square root and the output register. One target can enter every cycle;
// the throughput is one result per cycle as long as the receiver takes them.
// A stall of the receiver freezes the whole pipeline through one enable, so
// in_ch.ready drops only while an output transfer is held back.
// Reset clears all valid bits and loads the link length with 254 mm.
`include "assert_macros.svh"

module two_link_inverse_kinematics #(
  parameter int CORDIC_STAGES = tlik_pkg::CORDIC_STAGES_DEF,
  parameter int POS_BITS      = tlik_pkg::POS_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [tlik_pkg::LINK_W-1:0] cfg_wdata_i,
  tlik_in_if.sink                     in_ch,
  tlik_out_if.source                  out_ch
);
  import tlik_pkg::*;

  localparam int R2_W  = 2 * POS_BITS;
  localparam int CMP_W = (R2_W > LIM_W) ? R2_W : LIM_W;
  localparam int L2_W  = 2 * LINK_W;

  logic [LINK_W-1:0] link_q;
  logic              en;

  logic                    out_valid_q;
  logic signed [ANG_W-1:0] out_sh_q;
  logic signed [ANG_W-1:0] out_l2_q;
  logic                    out_unr_q;

  // The pipeline moves whenever the output register is empty or being taken.
  assign en          = !out_valid_q || out_ch.ready;
  assign in_ch.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      link_q <= LINK_RESET;
    end else if (cfg_we_i) begin
      link_q <= cfg_wdata_i;
    end
  end

  // Stage A: magnitudes squared and the square of the link length.
  logic [POS_BITS-1:0]        ax, ay;
  logic [R2_W-1:0]            ax2, ay2;
  logic [L2_W-1:0]            l2;
  logic                       a_v_q;
  logic signed [POS_BITS-1:0] a_x_q, a_y_q;
  logic                       a_left_q;
  logic [R2_W-1:0]            a_ax2_q, a_ay2_q;
  logic [L2_W-1:0]            a_l2_q;

  assign ax  = in_ch.x_pos[POS_BITS-1] ? POS_BITS'(-in_ch.x_pos) : POS_BITS'(in_ch.x_pos);
  assign ay  = in_ch.y_pos[POS_BITS-1] ? POS_BITS'(-in_ch.y_pos) : POS_BITS'(in_ch.y_pos);
  assign ax2 = R2_W'(ax) * R2_W'(ax);
  assign ay2 = R2_W'(ay) * R2_W'(ay);
  assign l2  = L2_W'(link_q) * L2_W'(link_q);

  // Stage B: squared distance and the squared reach 4 L^2.
  logic                       b_v_q;
  logic signed [POS_KEEP-1:0] b_x_q, b_y_q;
  logic                       b_left_q;
  logic [CMP_W-1:0]           b_r2_q;
  logic [LIM_W-1:0]           b_lim_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
      b_v_q <= 1'b0;
    end else if (en) begin
      a_v_q <= in_ch.valid;
      b_v_q <= a_v_q;
    end
  end

  // Reachable targets fit in POS_KEEP bits, so the narrow copy is exact
  // wherever it matters.
  always_ff @(posedge clk_i) begin
    if (en) begin
      a_x_q    <= in_ch.x_pos;
      a_y_q    <= in_ch.y_pos;
      a_left_q <= in_ch.arm_left;
      a_ax2_q  <= ax2;
      a_ay2_q  <= ay2;
      a_l2_q   <= l2;
      b_x_q    <= POS_KEEP'(a_x_q);
      b_y_q    <= POS_KEEP'(a_y_q);
      b_left_q <= a_left_q;
      b_r2_q   <= CMP_W'(a_ax2_q) + CMP_W'(a_ay2_q);
      b_lim_q  <= LIM_W'(a_l2_q) << 2;
    end
  end

  // Reach test and square root radicands go in with the alpha CORDIC.
  alpha_side_t             as_in, as_out;
  logic [CMP_W-1:0]        lim_ext, lim_diff;
  logic                    al_v;
  logic signed [ANG_W-1:0] al_ang;
  logic [$bits(alpha_side_t)-1:0] al_side;

  assign lim_ext       = CMP_W'(b_lim_q);
  assign lim_diff      = lim_ext - b_r2_q;
  assign as_in.x       = b_x_q;
  assign as_in.y       = b_y_q;
  assign as_in.left    = b_left_q;
  assign as_in.unreach = b_r2_q > lim_ext;
  assign as_in.origin  = b_r2_q == '0;
  assign as_in.rad_r   = RAD_W'(b_r2_q[LIM_W-1:0]) << SQ_SHIFT;
  assign as_in.rad_h   = RAD_W'(lim_diff[LIM_W-1:0]) << SQ_SHIFT;

  tlik_vec #(
    .STAGES (CORDIC_STAGES),
    .SIDE_W ($bits(alpha_side_t))
  ) u_alpha (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (b_v_q),
    .x_i     (VEC_W'(b_x_q) <<< POS_SCALE),
    .y_i     (VEC_W'(b_y_q) <<< POS_SCALE),
    .side_i  (as_in),
    .valid_o (al_v),
    .ang_o   (al_ang),
    .side_o  (al_side)
  );

  assign as_out = al_side;

  // Distance r and the elbow height h as square roots in 1/65536 mm.
  root_side_t         rs_in, bs;
  logic               sq_v;
  logic [ROOT_W-1:0]  sq_r, sq_h;
  logic [$bits(root_side_t)-1:0] sq_side, bt_side;

  assign rs_in.x       = as_out.x;
  assign rs_in.y       = as_out.y;
  assign rs_in.left    = as_out.left;
  assign rs_in.unreach = as_out.unreach;
  assign rs_in.origin  = as_out.origin;
  assign rs_in.alpha   = al_ang;

  tlik_isqrt #(
    .SIDE_W ($bits(root_side_t))
  ) u_isqrt (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (al_v),
    .rad_a_i  (as_out.rad_r),
    .rad_b_i  (as_out.rad_h),
    .side_i   (rs_in),
    .valid_o  (sq_v),
    .root_a_o (sq_r),
    .root_b_o (sq_h),
    .side_o   (sq_side)
  );

  // beta = acos(r / 2L) as the angle of the vector (r, h).
  logic                    bt_v;
  logic signed [ANG_W-1:0] bt_ang;

  tlik_vec #(
    .STAGES (CORDIC_STAGES),
    .SIDE_W ($bits(root_side_t))
  ) u_beta (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (sq_v),
    .x_i     (VEC_W'(sq_r)),
    .y_i     (VEC_W'(sq_h)),
    .side_i  (sq_side),
    .valid_o (bt_v),
    .ang_o   (bt_ang),
    .side_o  (bt_side)
  );

  assign bs = bt_side;

  // Shoulder angle: alpha minus beta for the right arm, plus for the left,
  // wrapped into one turn. A target at the origin takes beta as a quarter turn.
  logic signed [SUM_W-1:0] beta, t1_sum, t1_wrap;
  logic signed [ANG_W-1:0] t1;

  always_comb begin
    beta   = bs.origin ? SUM_W'(HALF_PI_Q) : SUM_W'(bt_ang);
    t1_sum = bs.left ? (SUM_W'(bs.alpha) + beta) : (SUM_W'(bs.alpha) - beta);
    if (t1_sum > PI_Q) begin
      t1_wrap = t1_sum - TWO_PI_Q;
    end else if (t1_sum < -PI_Q) begin
      t1_wrap = t1_sum + TWO_PI_Q;
    end else begin
      t1_wrap = t1_sum;
    end
    t1 = clamp_ang(t1_wrap);
  end

  // Elbow position L (cos t1, sin t1) in 1/65536 mm.
  rot_side_t               ro_in, ro_out;
  logic                    ro_v;
  logic signed [VEC_W-1:0] ro_c, ro_s;
  logic [$bits(rot_side_t)-1:0] ro_side;

  assign ro_in.x       = bs.x;
  assign ro_in.y       = bs.y;
  assign ro_in.unreach = bs.unreach;
  assign ro_in.t1      = t1;

  tlik_rot #(
    .STAGES (CORDIC_STAGES),
    .SIDE_W ($bits(rot_side_t))
  ) u_elbow (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (bt_v),
    .len_i   (LEN_W'(link_q) << POS_SCALE),
    .ang_i   (t1),
    .side_i  (ro_in),
    .valid_o (ro_v),
    .cos_o   (ro_c),
    .sin_o   (ro_s),
    .side_o  (ro_side)
  );

  assign ro_out = ro_side;

  // Second link angle: direction from the elbow to the target.
  fin_side_t               fs_in, fs_out;
  logic                    l2_v;
  logic signed [ANG_W-1:0] l2_ang;
  logic [$bits(fin_side_t)-1:0] l2_side;

  assign fs_in.unreach = ro_out.unreach;
  assign fs_in.t1      = ro_out.t1;

  tlik_vec #(
    .STAGES (CORDIC_STAGES),
    .SIDE_W ($bits(fin_side_t))
  ) u_link2 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (ro_v),
    .x_i     ((VEC_W'(ro_out.x) <<< POS_SCALE) - ro_c),
    .y_i     ((VEC_W'(ro_out.y) <<< POS_SCALE) - ro_s),
    .side_i  (fs_in),
    .valid_o (l2_v),
    .ang_o   (l2_ang),
    .side_o  (l2_side)
  );

  assign fs_out = l2_side;

  // Output register; unreachable targets report both angles as zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= l2_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_unr_q <= fs_out.unreach;
      out_sh_q  <= fs_out.unreach ? '0 : fs_out.t1;
      out_l2_q  <= fs_out.unreach ? '0 : clamp_ang(SUM_W'(l2_ang));
    end
  end

  assign out_ch.valid          = out_valid_q;
  assign out_ch.shoulder_angle = out_sh_q;
  assign out_ch.link2_angle    = out_l2_q;
  assign out_ch.unreachable    = out_unr_q;

  `TLIK_ASSERT(a_unreach_zero, clk_i, rst_ni, out_valid_q && out_unr_q |-> out_sh_q == '0 && out_l2_q == '0)
  `TLIK_ASSERT_NEVER(a_shoulder_range, clk_i, rst_ni, out_valid_q && (out_sh_q > ANG_LIMIT || out_sh_q < -ANG_LIMIT))
  `TLIK_ASSERT_NEVER(a_link2_range, clk_i, rst_ni, out_valid_q && (out_l2_q > ANG_LIMIT || out_l2_q < -ANG_LIMIT))
  `TLIK_ASSERT(a_held_result, clk_i, rst_ni, out_valid_q && !out_ch.ready |=> out_valid_q && !in_ch.ready == !out_ch.ready)

endmodule

// ===== test/tb_two_link_inverse_kinematics.sv =====
// Testbench for the two-link inverse kinematics pipeline: directed and random targets.
`timescale 1ns / 1ps

module tb_two_link_inverse_kinematics;
  import tlik_pkg::*;

  localparam int STAGES     = CORDIC_STAGES_DEF;
  localparam int LATENCY    = 34 + 4 * STAGES;
  localparam int CYCLE_CAP  = 1000000;
  localparam longint POS_MIN = -131072;
  localparam longint POS_MAX = 131071;

  // Arctangent of 2^-i in 2^-16 rad, rounded to nearest.
  localparam longint ATAN_STEP [0:16] = '{51472, 30385, 16055, 8150, 4091, 2047, 1024,
                                          512, 256, 128, 64, 32, 16, 8, 4, 2, 1};

  typedef struct {
    logic signed [ANG_W-1:0] shoulder;
    logic signed [ANG_W-1:0] link2;
    logic                    unreach;
  } joint_angles_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i;
  logic [LINK_W-1:0] cfg_wdata_i;

  tlik_in_if  in_ch ();
  tlik_out_if out_ch ();

  two_link_inverse_kinematics dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_ch       (in_ch),
    .out_ch      (out_ch)
  );

  always #5 clk_i = ~clk_i;

  // Our own copy of the link length register, updated with each write.
  longint        link_len = LINK_RESET;
  joint_angles_t pending_angles[$];
  int            error_count = 0;
  int            cycle_count = 0;
  bit            calm = 1'b0;   // no idling on either side when set

  // Timeout watchdog.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_CAP) begin
      $display("tb_two_link_inverse_kinematics: errors");
      $finish;
    end
  end

  // Integer square root, floor.
  function automatic longint int_root(longint v);
    longint res;
    longint bitv;
    res = 0;
    bitv = longint'(1) <<< 62;
    while (bitv > v) bitv = bitv >>> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >>> 1) + bitv;
      end else begin
        res = res >>> 1;
      end
      bitv = bitv >>> 2;
    end
    return res;
  endfunction

  // atan2(y, x) by vectoring CORDIC; shifts of signed values floor.
  function automatic longint heading(longint x, longint y);
    longint z;
    longint t;
    longint dx;
    longint dy;
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y; y = -t; z = HALF_PI_Q;
      end else begin
        x = -y; y = t; z = -HALF_PI_Q;
      end
    end
    for (int i = 0; i < STAGES; i++) begin
      dx = x >>> i;
      dy = y >>> i;
      if (y > 0) begin
        x = x + dy; y = y - dx; z = z + ATAN_STEP[i];
      end else begin
        x = x - dy; y = y + dx; z = z - ATAN_STEP[i];
      end
    end
    return z;
  endfunction

  // len*cos(ang), len*sin(ang) by rotation CORDIC, gain pre-compensated.
  function automatic void elbow_point(longint len, longint ang, output longint c,
                                      output longint s);
    longint x;
    longint y;
    longint nx;
    longint ny;
    x = (len * longint'(KINV_Q30)) >>> 30;
    y = 0;
    if (ang > HALF_PI_Q) begin
      y = x; x = 0; ang = ang - HALF_PI_Q;
    end else if (ang < -HALF_PI_Q) begin
      y = -x; x = 0; ang = ang + HALF_PI_Q;
    end
    for (int i = 0; i < STAGES; i++) begin
      if (ang >= 0) begin
        nx = x - (y >>> i); ny = y + (x >>> i); ang = ang - ATAN_STEP[i];
      end else begin
        nx = x + (y >>> i); ny = y - (x >>> i); ang = ang + ATAN_STEP[i];
      end
      x = nx; y = ny;
    end
    c = x;
    s = y;
  endfunction

  function automatic longint clamp_angle(longint a);
    if (a > ANG_LIMIT) return ANG_LIMIT;
    if (a < -ANG_LIMIT) return -ANG_LIMIT;
    return a;
  endfunction

  // Joint angles for one target under the current link length.
  function automatic joint_angles_t solve_joints(longint x, longint y, bit left);
    joint_angles_t res;
    longint r2;
    longint reach2;
    longint alpha;
    longint beta;
    longint t1;
    longint t2;
    longint c;
    longint s;
    r2 = x * x + y * y;
    reach2 = 4 * link_len * link_len;
    res.shoulder = '0;
    res.link2 = '0;
    res.unreach = 1'b0;
    if (r2 > reach2) begin
      res.unreach = 1'b1;
      return res;
    end
    alpha = heading(x * 256, y * 256);
    // At the origin the elbow stands square to the target direction.
    if (r2 == 0) begin
      beta = HALF_PI_Q;
    end else begin
      beta = heading(int_root(r2 <<< 16), int_root((reach2 - r2) <<< 16));
    end
    t1 = left ? alpha + beta : alpha - beta;
    if (t1 > PI_Q) t1 = t1 - TWO_PI_Q;
    else if (t1 < -PI_Q) t1 = t1 + TWO_PI_Q;
    t1 = clamp_angle(t1);
    elbow_point(link_len * 256, t1, c, s);
    t2 = clamp_angle(heading(x * 256 - c, y * 256 - s));
    res.shoulder = ANG_W'(t1);
    res.link2 = ANG_W'(t2);
    return res;
  endfunction

  function automatic longint clip_pos(longint v);
    if (v > POS_MAX) return POS_MAX;
    if (v < POS_MIN) return POS_MIN;
    return v;
  endfunction

  // Receiver: random stall bursts while not calm.
  initial begin
    out_ch.ready <= 1'b1;
    forever begin
      @(posedge clk_i);
      if (!calm && $urandom_range(0, 9) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk_i);
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Every output transfer is checked against the oldest prediction.
  always @(posedge clk_i) begin
    joint_angles_t exp_a;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (pending_angles.size() == 0) begin
        $error("unexpected result: shoulder_angle %0d link2_angle %0d unreachable %0b",
               out_ch.shoulder_angle, out_ch.link2_angle, out_ch.unreachable);
        error_count++;
      end else begin
        exp_a = pending_angles.pop_front();
        if (out_ch.shoulder_angle !== exp_a.shoulder) begin
          $error("shoulder_angle expected %0d actual %0d", exp_a.shoulder,
                 out_ch.shoulder_angle);
          error_count++;
        end
        if (out_ch.link2_angle !== exp_a.link2) begin
          $error("link2_angle expected %0d actual %0d", exp_a.link2, out_ch.link2_angle);
          error_count++;
        end
        if (out_ch.unreachable !== exp_a.unreach) begin
          $error("unreachable expected %0b actual %0b", exp_a.unreach,
                 out_ch.unreachable);
          error_count++;
        end
      end
    end
  end

  // Offers one target and holds it until the transfer happens. Valid is left
  // high when no gap follows, so back-to-back targets keep it asserted.
  task automatic send_target(longint x, longint y, bit left);
    in_ch.x_pos    <= POS_KEEP'(x);
    in_ch.y_pos    <= POS_KEEP'(y);
    in_ch.arm_left <= left;
    in_ch.valid    <= 1'b1;
    do @(posedge clk_i); while (!in_ch.ready);
    pending_angles.push_back(solve_joints(x, y, left));
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
  endtask

  // Lowers valid, then waits until all predictions are matched and the
  // pipeline has run empty.
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_angles.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 8) @(posedge clk_i);
  endtask

  // The link length is changed only with the pipeline empty.
  task automatic set_link(longint len);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= LINK_W'(len);
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    link_len = len;
    @(posedge clk_i);
  endtask

  // A random target: mostly in the square around the reach disc, some on its rim, some anywhere.
  task automatic send_random();
    longint span;
    longint x;
    longint y;
    int pick;
    span = 2 * link_len;
    pick = $urandom_range(0, 9);
    if (pick < 6) begin
      x = clip_pos(longint'($urandom_range(0, 2 * span)) - span);
      y = clip_pos(longint'($urandom_range(0, 2 * span)) - span);
    end else if (pick < 8) begin
      x = clip_pos(longint'($urandom_range(0, 2 * span)) - span);
      y = int_root(span * span - x * x) + longint'($urandom_range(0, 2)) - 1;
      if ($urandom_range(0, 1)) y = -y;
      y = clip_pos(y);
    end else begin
      x = longint'($urandom_range(0, 262143)) + POS_MIN;
      y = longint'($urandom_range(0, 262143)) + POS_MIN;
    end
    send_target(x, y, $urandom_range(0, 1));
  endtask

  // Edges of reach, the origin, quadrant boundaries and field extremes.
  task automatic test_directed();
    longint span;
    span = 2 * link_len;
    send_target(0, 0, 1'b0);
    send_target(0, 0, 1'b1);
    send_target(span, 0, 1'b0);
    send_target(span + 1, 0, 1'b1);
    send_target(-span, 0, 1'b1);
    send_target(0, -span, 1'b0);
    send_target(-1, 0, 1'b0);
    send_target(-1, -1, 1'b1);
    send_target(1, 1, 1'b0);
    send_target(POS_MIN, POS_MIN, 1'b0);
    send_target(POS_MAX, POS_MAX, 1'b1);
    send_target(-70000, 50000, 1'b1);
    send_target(-70000, -50000, 1'b0);
    set_link(65535);
    send_target(POS_MAX, 0, 1'b0);
    send_target(POS_MIN, 0, 1'b1);
    send_target(0, 131070, 1'b1);
    set_link(1);
    send_target(0, 0, 1'b1);
    send_target(2, 0, 1'b0);
    send_target(1, 1, 1'b1);
    send_target(0, -2, 1'b0);
    send_target(3, 0, 1'b1);
    // A zero link length leaves only the origin within reach.
    set_link(0);
    send_target(0, 0, 1'b0);
    send_target(1, 0, 1'b1);
  endtask

  // Random targets over several link lengths, extremes among them.
  task automatic test_random_lengths();
    longint len;
    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0:       len = 65535;
        1:       len = 1;
        2:       len = LINK_RESET;
        3:       len = $urandom_range(2, 300);
        default: len = $urandom_range(1, 65535);
      endcase
      set_link(len);
      repeat (220) send_random();
    end
  endtask

  // The sender stops until every outstanding result has come back.
  task automatic test_drain_pause();
    set_link($urandom_range(20000, 65535));
    repeat (60) send_random();
    drain();
    repeat (60) send_random();
  endtask

  // Final stretch with neither side idling, at full rate.
  task automatic test_full_rate();
    set_link($urandom_range(1, 65535));
    calm = 1'b1;
    repeat (150) send_random();
  endtask

  initial begin
    rst_ni         <= 1'b0;
    cfg_we_i       <= 1'b0;
    cfg_wdata_i    <= '0;
    in_ch.valid    <= 1'b0;
    in_ch.x_pos    <= '0;
    in_ch.y_pos    <= '0;
    in_ch.arm_left <= 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_random_lengths();
    test_drain_pause();
    test_full_rate();
    drain();

    if (error_count == 0) begin
      $display("tb_two_link_inverse_kinematics: clean");
    end else begin
      $display("tb_two_link_inverse_kinematics: errors");
    end
    $finish;
  end

endmodule
